>>> rtl/pmsr_pkg.sv
// Shared types, constants and codes of the motor soft-start ramp block.
package pmsr_pkg;

  // Number of motors and the width of a motor index
  localparam int MOTOR_COUNT = 2;
  localparam int MIDX_W      = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  // Percent scale and serial divider size
  localparam logic [6:0] PCT_FULL = 7'd100;
  localparam int         DIV_W    = 21;
  localparam int         DCNT_W   = $clog2(DIV_W);

  // Reciprocal of the percent scale: x / 100 == (x * RECIP_100) >> RECIP_SH for x < 2**DIV_W
  localparam logic [21:0] RECIP_100 = 22'd2684355;
  localparam int          RECIP_W   = 22;
  localparam int          RECIP_SH  = 28;

  // Request kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_DIRECT = 2'd1;
  localparam logic [1:0] KIND_SOFT   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_SPEED = 2'd0;
  localparam logic [1:0] CFG_FULL_DUTY = 2'd1;
  localparam logic [1:0] CFG_TICKS     = 2'd2;

  // Configuration reset values
  localparam logic [6:0]  MIN_SPEED_RST = 7'd30;
  localparam logic [13:0] FULL_DUTY_RST = 14'd8191;
  localparam logic [9:0]  TICKS_RST     = 10'd10;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STOP,
    PH_HOLD,
    PH_RAMP
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CALC,
    S_DIVA,
    S_MID,
    S_DIVB,
    S_PUSH
  } fsm_t;

  // One motor's state entry
  typedef struct packed {
    logic [6:0]  speed;
    logic        dir;
    logic [6:0]  goal;
    logic        gdir;
    phase_t      phase;
    logic [10:0] wait_left;
  } entry_t;

  localparam entry_t RESET_ENTRY = '{
    speed:     7'd0,
    dir:       1'b1,
    goal:      7'd0,
    gdir:      1'b1,
    phase:     PH_IDLE,
    wait_left: 11'd0
  };

endpackage

>>> rtl/pwm_motor_soft_start_ramp.sv
// Top level of the per-motor soft-start ramp with forward and backward PWM duties.
// A command or tick request passes S_RD, S_CALC, S_DIVA, S_MID, the 21-step serial
// division by 100 - min_speed in S_DIVB, then S_PUSH; a rejected command goes from
// acceptance straight to S_PUSH. A tick gives one result per motor, the last marked.
// One request is worked at a time, the next taken the cycle after the last result is
// loaded; a stalled output holds the block.
// Reset (synchronous, rst_n low): registers return to defaults and all motors read at rest.
module pwm_motor_soft_start_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_motor,
  input  logic [6:0]  in_speed,
  input  logic        in_forward,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_unit,
  output logic [13:0] out_fwd_duty,
  output logic [13:0] out_bwd_duty,
  output logic        out_ramping,
  output logic        out_rejected,
  output logic        out_last
);

  localparam int N = pmsr_pkg::MOTOR_COUNT;
  localparam int IW = pmsr_pkg::MIDX_W;
  localparam int DW = pmsr_pkg::DIV_W;
  localparam int PW = pmsr_pkg::DIV_W + pmsr_pkg::RECIP_W;

  // Configuration registers
  logic [6:0]  min_r;
  logic [13:0] fd_r;
  logic [9:0]  tps_r;

  // Control
  pmsr_pkg::fsm_t state_r, state_nxt;
  logic           accept;
  logic           out_load;
  logic           mem_we;

  // Latched request
  logic [1:0]    kind_r;
  logic [3:0]    motor_r;
  logic [6:0]    spd_r;
  logic          fw_r;
  logic          rej_r;
  logic [IW-1:0] cur_r;
  logic          cur_last;

  // State memory with valid bits
  pmsr_pkg::entry_t mem [N];
  logic [N-1:0]     vld_r;
  pmsr_pkg::entry_t mem_q_r;
  logic             rvld_r;
  pmsr_pkg::entry_t ent;
  pmsr_pkg::entry_t upd;

  // Duty datapath
  logic [6:0]        spd_q_r;
  logic              dir_q_r;
  logic              ramp_q_r;
  logic              dzero_r;
  logic [13:0]       base_r;
  logic [DW-1:0]     dvd_r;
  logic [6:0]        dvs_r;
  logic [6:0]        rem_r;
  logic [pmsr_pkg::DCNT_W-1:0] cnt_r;
  logic [7:0]        trial;
  logic              trial_ge;
  logic [6:0]        rem_step;
  logic              div_last;
  logic [6:0]        m_cl;
  logic [6:0]        s_cl;
  logic              m_full;
  logic [DW-1:0]     mul_a;
  logic [DW-1:0]     mul_b;
  logic [PW-1:0]     prod_a;
  logic [DW-1:0]     quo_a;
  logic [13:0]       duty;

  // Output registers
  logic        out_valid_r;
  logic [3:0]  unit_r;
  logic [13:0] fwd_r;
  logic [13:0] bwd_r;
  logic        ramping_r;
  logic        rejected_r;
  logic        last_r;

  // Ramp entry helpers
  function automatic pmsr_pkg::entry_t enter_ramp(pmsr_pkg::entry_t e, logic [6:0] s,
                                                  logic [9:0] tps);
    pmsr_pkg::entry_t r;
    r = e;
    if (s == e.goal) begin
      r.speed     = e.goal;
      r.phase     = pmsr_pkg::PH_IDLE;
      r.wait_left = '0;
    end else begin
      r.speed     = s;
      r.phase     = pmsr_pkg::PH_RAMP;
      r.wait_left = {1'b0, tps};
    end
    return r;
  endfunction

  function automatic pmsr_pkg::entry_t enter_run(pmsr_pkg::entry_t e, logic [6:0] s,
                                                 logic [6:0] mn, logic [9:0] tps);
    pmsr_pkg::entry_t r;
    r = e;
    r.dir = e.gdir;
    if (e.goal == 7'd0) begin
      r.speed     = '0;
      r.phase     = pmsr_pkg::PH_IDLE;
      r.wait_left = '0;
    end else if (s == 7'd0) begin
      r.speed     = mn;
      r.phase     = pmsr_pkg::PH_HOLD;
      r.wait_left = {tps, 1'b0};
    end else begin
      r = enter_ramp(r, s, tps);
    end
    return r;
  endfunction

  function automatic pmsr_pkg::entry_t advance(pmsr_pkg::entry_t e, logic [6:0] mn,
                                               logic [9:0] tps);
    pmsr_pkg::entry_t r;
    logic [6:0]       sp;
    r  = e;
    sp = (e.goal > e.speed) ? e.speed + 7'd1 : e.speed - 7'd1;
    if (e.phase != pmsr_pkg::PH_IDLE) begin
      if (e.wait_left > 11'd1) begin
        r.wait_left = e.wait_left - 11'd1;
      end else begin
        case (e.phase)
          pmsr_pkg::PH_STOP: begin
            if (e.speed > mn) begin
              r.speed     = e.speed - 7'd1;
              r.wait_left = {1'b0, tps};
            end else begin
              r.speed = '0;
              r = enter_run(r, 7'd0, mn, tps);
            end
          end
          pmsr_pkg::PH_HOLD: r = enter_ramp(r, mn, tps);
          pmsr_pkg::PH_RAMP: r = enter_ramp(r, sp, tps);
          default: r = e;
        endcase
      end
    end
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= pmsr_pkg::MIN_SPEED_RST;
      fd_r  <= pmsr_pkg::FULL_DUTY_RST;
      tps_r <= pmsr_pkg::TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pmsr_pkg::CFG_MIN_SPEED: min_r <= cfg_data[6:0];
        pmsr_pkg::CFG_FULL_DUTY: fd_r  <= cfg_data;
        pmsr_pkg::CFG_TICKS:     tps_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmsr_pkg::S_IDLE: begin
        if (accept && in_kind != pmsr_pkg::KIND_NONE) begin
          if (in_kind != pmsr_pkg::KIND_TICK && in_motor >= 4'(N)) begin
            state_nxt = pmsr_pkg::S_PUSH;
          end else begin
            state_nxt = pmsr_pkg::S_RD;
          end
        end
      end
      pmsr_pkg::S_RD:   state_nxt = pmsr_pkg::S_CALC;
      pmsr_pkg::S_CALC: state_nxt = pmsr_pkg::S_DIVA;
      pmsr_pkg::S_DIVA: state_nxt = pmsr_pkg::S_MID;
      pmsr_pkg::S_MID:  state_nxt = pmsr_pkg::S_DIVB;
      pmsr_pkg::S_DIVB: if (div_last) state_nxt = pmsr_pkg::S_PUSH;
      pmsr_pkg::S_PUSH: begin
        if (out_load) begin
          if (!rej_r && kind_r == pmsr_pkg::KIND_TICK && !cur_last) begin
            state_nxt = pmsr_pkg::S_RD;
          end else begin
            state_nxt = pmsr_pkg::S_IDLE;
          end
        end
      end
      default: state_nxt = pmsr_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = (state_r == pmsr_pkg::S_IDLE);
    out_load = (state_r == pmsr_pkg::S_PUSH) && (!out_valid_r || out_ready);
    mem_we   = (state_r == pmsr_pkg::S_CALC);
  end

  assign accept   = in_valid && in_ready;
  assign cur_last = (cur_r == IW'(N - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmsr_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // State memory: read into a register in S_RD, write back the updated entry in S_CALC
  always_ff @(posedge clk) begin
    if (state_r == pmsr_pkg::S_RD) begin
      mem_q_r <= mem[cur_r];
      rvld_r  <= vld_r[cur_r];
    end
    if (mem_we) begin
      mem[cur_r] <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[cur_r] <= 1'b1;
    end
  end

  // Apply the request to the entry
  always_comb begin
    ent = rvld_r ? mem_q_r : pmsr_pkg::RESET_ENTRY;
    upd = ent;
    case (kind_r)
      pmsr_pkg::KIND_TICK: upd = advance(ent, min_r, tps_r);
      pmsr_pkg::KIND_DIRECT: begin
        upd.speed     = (spd_r < min_r) ? 7'd0 : spd_r;
        upd.dir       = fw_r;
        upd.goal      = (spd_r < min_r) ? 7'd0 : spd_r;
        upd.gdir      = fw_r;
        upd.phase     = pmsr_pkg::PH_IDLE;
        upd.wait_left = '0;
      end
      pmsr_pkg::KIND_SOFT: begin
        upd.goal = spd_r;
        upd.gdir = fw_r;
        if (ent.dir != fw_r && ent.speed != 7'd0) begin
          if (ent.speed >= min_r) begin
            upd.phase     = pmsr_pkg::PH_STOP;
            upd.wait_left = {1'b0, tps_r};
          end else begin
            upd.speed = '0;
            upd = enter_run(upd, 7'd0, min_r, tps_r);
          end
        end else begin
          upd = enter_run(upd, ent.speed, min_r, tps_r);
        end
      end
      default: upd = ent;
    endcase
  end

  // Duty mapping operands, reciprocal divide by the percent scale and serial divider step
  always_comb begin
    m_cl     = (min_r > pmsr_pkg::PCT_FULL) ? pmsr_pkg::PCT_FULL : min_r;
    s_cl     = (spd_q_r > pmsr_pkg::PCT_FULL) ? pmsr_pkg::PCT_FULL : spd_q_r;
    m_full   = (m_cl == pmsr_pkg::PCT_FULL);
    mul_a    = DW'(m_cl) * DW'(fd_r);
    mul_b    = DW'(s_cl - m_cl) * DW'(fd_r - dvd_r[13:0]);
    prod_a   = PW'(dvd_r) * PW'(pmsr_pkg::RECIP_100);
    quo_a    = DW'(prod_a >> pmsr_pkg::RECIP_SH);
    trial    = {rem_r, dvd_r[DW-1]};
    trial_ge = (trial >= {1'b0, dvs_r});
    rem_step = trial_ge ? 7'(trial - {1'b0, dvs_r}) : trial[6:0];
    div_last = (cnt_r == pmsr_pkg::DCNT_W'(DW - 1));
    duty     = dzero_r ? 14'd0 : 14'(base_r + dvd_r[13:0]);
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      pmsr_pkg::S_IDLE: begin
        if (accept) begin
          kind_r  <= in_kind;
          motor_r <= in_motor;
          spd_r   <= (in_speed > pmsr_pkg::PCT_FULL) ? pmsr_pkg::PCT_FULL : in_speed;
          fw_r    <= in_forward;
          rej_r   <= (in_kind != pmsr_pkg::KIND_TICK) && (in_motor >= 4'(N));
          cur_r   <= (in_kind == pmsr_pkg::KIND_TICK) ? '0 : in_motor[IW-1:0];
        end
      end
      pmsr_pkg::S_CALC: begin
        spd_q_r  <= upd.speed;
        dir_q_r  <= upd.dir;
        ramp_q_r <= (upd.phase != pmsr_pkg::PH_IDLE);
        dzero_r  <= (upd.speed < min_r) || (upd.speed == 7'd0);
        // product for base = m * full / 100
        dvd_r    <= mul_a;
      end
      pmsr_pkg::S_DIVA: begin
        // divide the product by the percent scale through its reciprocal
        dvd_r <= quo_a;
      end
      pmsr_pkg::S_MID: begin
        // start (s - m) * (full - base) / (100 - m); a zero term when m is full scale
        base_r <= dvd_r[13:0];
        dvd_r  <= m_full ? '0 : mul_b;
        dvs_r  <= m_full ? 7'd1 : 7'(pmsr_pkg::PCT_FULL - m_cl);
        rem_r  <= '0;
        cnt_r  <= '0;
      end
      pmsr_pkg::S_DIVB: begin
        rem_r <= rem_step;
        dvd_r <= {dvd_r[DW-2:0], trial_ge};
        cnt_r <= cnt_r + 1'b1;
      end
      pmsr_pkg::S_PUSH: begin
        if (out_load && !rej_r && kind_r == pmsr_pkg::KIND_TICK && !cur_last) begin
          cur_r <= cur_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register: hold while stalled, load a new result when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rej_r) begin
        unit_r     <= motor_r;
        fwd_r      <= '0;
        bwd_r      <= '0;
        ramping_r  <= 1'b0;
        rejected_r <= 1'b1;
        last_r     <= 1'b1;
      end else begin
        unit_r     <= 4'(cur_r);
        fwd_r      <= dir_q_r ? duty : 14'd0;
        bwd_r      <= dir_q_r ? 14'd0 : duty;
        ramping_r  <= ramp_q_r;
        rejected_r <= 1'b0;
        last_r     <= (kind_r != pmsr_pkg::KIND_TICK) || cur_last;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_unit     = unit_r;
  assign out_fwd_duty = fwd_r;
  assign out_bwd_duty = bwd_r;
  assign out_ramping  = ramping_r;
  assign out_rejected = rejected_r;
  assign out_last     = last_r;

endmodule

>>> rtl/pmsr_checker.sv
// Port-level checker for the soft-start ramp block, bound to the top level.
module pmsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_unit,
  input logic [13:0] out_fwd_duty,
  input logic [13:0] out_bwd_duty,
  input logic        out_ramping,
  input logic        out_rejected,
  input logic        out_last
);

  // Drop any pending result on reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_unit) && $stable(out_fwd_duty)
      && $stable(out_bwd_duty) && $stable(out_last))
    else $error("stalled result changed");

  // A rejected request closes its item with no drive
  a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_last && out_fwd_duty == 14'd0
      && out_bwd_duty == 14'd0 && !out_ramping)
    else $error("malformed reject result");

  // Never drive both bridge halves
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fwd_duty == 14'd0 || out_bwd_duty == 14'd0))
    else $error("both duties non-zero");

  // Accepted results name an existing motor
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rejected |-> out_unit < 4'(pmsr_pkg::MOTOR_COUNT))
    else $error("result for a missing motor");

endmodule

bind pwm_motor_soft_start_ramp pmsr_checker u_pmsr_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for the motor soft-start ramp: random and directed requests.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0] kind;
    logic [3:0] motor;
    logic [6:0] speed;
    logic       forward;
  } motor_req_t;

  typedef struct {
    logic [3:0]  unit;
    logic [13:0] fwd;
    logic [13:0] bwd;
    logic        ramping;
    logic        rejected;
    logic        last;
  } duty_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = pmsr_pkg::CFG_MIN_SPEED;
  logic [13:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = pmsr_pkg::KIND_TICK;
  logic [3:0]  in_motor = '0;
  logic [6:0]  in_speed = '0;
  logic        in_forward = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_unit;
  logic [13:0] out_fwd_duty;
  logic [13:0] out_bwd_duty;
  logic        out_ramping;
  logic        out_rejected;
  logic        out_last;

  pwm_motor_soft_start_ramp u_top (.*);

  // Pending requests, requests on the port, duties still owed by the block
  motor_req_t   req_q[$];
  motor_req_t   cur_req;
  duty_report_t duty_q[$];
  int           errors = 0;
  int           items_sent = 0;
  int           src_idle_pct = 0;
  int           snk_idle_pct = 0;
  int           holds_asked = 0;
  int           holds_done = 0;
  int           hold_left = 0;

  // Own copy of the registers and the per-motor ramp state
  logic [6:0]       min_spd;
  logic [13:0]      full_dty;
  logic [9:0]       step_ticks;
  logic [6:0]       spd_now  [pmsr_pkg::MOTOR_COUNT];
  logic             dir_now  [pmsr_pkg::MOTOR_COUNT];
  logic [6:0]       spd_goal [pmsr_pkg::MOTOR_COUNT];
  logic             dir_goal [pmsr_pkg::MOTOR_COUNT];
  pmsr_pkg::phase_t ramp_ph  [pmsr_pkg::MOTOR_COUNT];
  logic [10:0]      wait_cnt [pmsr_pkg::MOTOR_COUNT];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Map a speed percent linearly onto min..full duty
  function automatic logic [13:0] duty_for(int unsigned s);
    int unsigned m;
    int unsigned base;
    m = (min_spd > 100) ? 100 : min_spd;
    if (s < min_spd) return '0;
    if (s > 100) s = 100;
    if (s == 0) return '0;
    base = (m * full_dty) / 100;
    if (m >= 100) return base[13:0];
    return 14'(base + ((s - m) * (full_dty - base)) / (100 - m));
  endfunction

  // Settle on the goal or keep ramping from the given speed
  function automatic void settle(int i, logic [6:0] s);
    spd_now[i] = s;
    if (s == spd_goal[i]) begin
      ramp_ph[i]  = pmsr_pkg::PH_IDLE;
      wait_cnt[i] = '0;
    end else begin
      ramp_ph[i]  = pmsr_pkg::PH_RAMP;
      wait_cnt[i] = 11'(step_ticks);
    end
  endfunction

  // Take up the goal direction; from standstill hold the minimum first
  function automatic void start_run(int i, logic [6:0] s);
    dir_now[i] = dir_goal[i];
    if (spd_goal[i] == 0) begin
      spd_now[i]  = '0;
      ramp_ph[i]  = pmsr_pkg::PH_IDLE;
      wait_cnt[i] = '0;
    end else if (s == 0) begin
      spd_now[i]  = min_spd;
      ramp_ph[i]  = pmsr_pkg::PH_HOLD;
      wait_cnt[i] = {step_ticks, 1'b0};
    end else begin
      settle(i, s);
    end
  endfunction

  // Advance one motor's ramp by one tick
  function automatic void step_motor(int i);
    logic [6:0] sp;
    sp = spd_now[i];
    if (ramp_ph[i] == pmsr_pkg::PH_IDLE) return;
    if (wait_cnt[i] > 1) begin
      wait_cnt[i] = wait_cnt[i] - 11'd1;
      return;
    end
    case (ramp_ph[i])
      pmsr_pkg::PH_STOP: begin
        if (sp > min_spd) begin
          spd_now[i]  = sp - 7'd1;
          wait_cnt[i] = 11'(step_ticks);
        end else begin
          spd_now[i] = '0;
          start_run(i, '0);
        end
      end
      pmsr_pkg::PH_HOLD: settle(i, min_spd);
      default: settle(i, (spd_goal[i] > sp) ? sp + 7'd1 : sp - 7'd1);
    endcase
  endfunction

  function automatic void owe_report(int i, logic last);
    duty_report_t r;
    logic [13:0]  d;
    d = duty_for(spd_now[i]);
    r.unit     = 4'(i);
    r.fwd      = dir_now[i] ? d : '0;
    r.bwd      = dir_now[i] ? '0 : d;
    r.ramping  = (ramp_ph[i] != pmsr_pkg::PH_IDLE);
    r.rejected = 1'b0;
    r.last     = last;
    duty_q.push_back(r);
  endfunction

  // Work out the duties owed for one accepted request
  function automatic void predict_request(motor_req_t q);
    logic [6:0]   spd;
    logic [6:0]   s0;
    duty_report_t r;
    int           i;
    spd = (q.speed > 100) ? 7'd100 : q.speed;
    i   = int'(q.motor);
    if (q.kind == pmsr_pkg::KIND_TICK) begin
      for (int k = 0; k < pmsr_pkg::MOTOR_COUNT; k++) begin
        step_motor(k);
        owe_report(k, k == pmsr_pkg::MOTOR_COUNT - 1);
      end
    end else if (q.kind == pmsr_pkg::KIND_NONE) begin
      return;
    end else if (q.motor >= pmsr_pkg::MOTOR_COUNT) begin
      r.unit     = q.motor;
      r.fwd      = '0;
      r.bwd      = '0;
      r.ramping  = 1'b0;
      r.rejected = 1'b1;
      r.last     = 1'b1;
      duty_q.push_back(r);
    end else if (q.kind == pmsr_pkg::KIND_DIRECT) begin
      s0 = (spd < min_spd) ? 7'd0 : spd;
      spd_now[i]  = s0;
      dir_now[i]  = q.forward;
      spd_goal[i] = s0;
      dir_goal[i] = q.forward;
      ramp_ph[i]  = pmsr_pkg::PH_IDLE;
      wait_cnt[i] = '0;
      owe_report(i, 1'b1);
    end else begin
      s0 = spd_now[i];
      spd_goal[i] = spd;
      dir_goal[i] = q.forward;
      if (dir_now[i] != q.forward && s0 > 0) begin
        if (s0 >= min_spd) begin
          ramp_ph[i]  = pmsr_pkg::PH_STOP;
          wait_cnt[i] = 11'(step_ticks);
        end else begin
          spd_now[i] = '0;
          start_run(i, '0);
        end
      end else begin
        start_run(i, s0);
      end
      owe_report(i, 1'b1);
    end
  endfunction

  // Drive requests from the pending queue; hold each until accepted
  always @(posedge clk) begin
    logic fire;
    fire = in_valid && in_ready;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) predict_request(cur_req);
      if (in_valid && !fire) begin
        // keep offering the same request
      end else if (req_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cur_req = req_q.pop_front();
        in_valid   <= 1'b1;
        in_kind    <= cur_req.kind;
        in_motor   <= cur_req.motor;
        in_speed   <= cur_req.speed;
        in_forward <= cur_req.forward;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left  <= 400;
      holds_done <= holds_done + 1;
    end
  end

  function automatic void check_field(string name, logic [13:0] want, logic [13:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Compare each delivered result with the oldest owed one
  always @(posedge clk) begin
    duty_report_t w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (duty_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got unit %0d", $time, out_unit);
          errors++;
        end else begin
          w = duty_q.pop_front();
          check_field("unit", 14'(w.unit), 14'(out_unit));
          check_field("fwd_duty", w.fwd, out_fwd_duty);
          check_field("bwd_duty", w.bwd, out_bwd_duty);
          check_field("ramping", 14'(w.ramping), 14'(out_ramping));
          check_field("rejected", 14'(w.rejected), 14'(out_rejected));
          check_field("last", 14'(w.last), 14'(out_last));
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic queue_req(logic [1:0] kind, logic [3:0] motor, logic [6:0] speed,
                           logic fwd);
    motor_req_t q;
    q.kind    = kind;
    q.motor   = motor;
    q.speed   = speed;
    q.forward = fwd;
    req_q.push_back(q);
    if (kind != pmsr_pkg::KIND_NONE) items_sent++;
  endtask

  function automatic logic [6:0] pick_speed();
    int s;
    case ($urandom_range(3))
      0:       s = $urandom_range(127);
      1:       s = $urandom_range(100);
      2:       s = int'(min_spd) + $urandom_range(5);
      default: s = ($urandom_range(1) == 0) ? 0 : $urandom_range(int'(min_spd));
    endcase
    return (s > 127) ? 7'd127 : 7'(s);
  endfunction

  // Mostly tick bursts and well-formed commands, some rejects and unused kinds
  task automatic queue_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      repeat ($urandom_range(1, 8)) queue_req(pmsr_pkg::KIND_TICK, 4'($urandom_range(15)),
                                              7'($urandom_range(127)), 1'($urandom));
    end else if (r < 72) begin
      queue_req(pmsr_pkg::KIND_SOFT, 4'($urandom_range(pmsr_pkg::MOTOR_COUNT - 1)),
                pick_speed(), 1'($urandom));
    end else if (r < 84) begin
      queue_req(pmsr_pkg::KIND_DIRECT, 4'($urandom_range(pmsr_pkg::MOTOR_COUNT - 1)),
                pick_speed(), 1'($urandom));
    end else if (r < 93) begin
      queue_req(($urandom_range(1) == 0) ? pmsr_pkg::KIND_SOFT : pmsr_pkg::KIND_DIRECT,
                4'($urandom_range(15)), 7'($urandom_range(127)), 1'($urandom));
    end else begin
      queue_req(pmsr_pkg::KIND_NONE, 4'($urandom_range(15)), 7'($urandom_range(127)),
                1'($urandom));
    end
  endtask

  task automatic queue_random(int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) queue_random_item();
  endtask

  // Wait until nothing is pending or owed, then let a possible unused kind clear
  task automatic drain();
    @(negedge clk);
    while (req_q.size() != 0 || in_valid || duty_q.size() != 0) @(negedge clk);
    repeat (100) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [13:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == pmsr_pkg::CFG_MIN_SPEED) min_spd = val[6:0];
    else if (idx == pmsr_pkg::CFG_FULL_DUTY) full_dty = val;
    else if (idx == pmsr_pkg::CFG_TICKS) step_ticks = val[9:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int ms, int fd, int tps);
    write_reg(pmsr_pkg::CFG_MIN_SPEED, 14'(ms));
    write_reg(pmsr_pkg::CFG_FULL_DUTY, 14'(fd));
    write_reg(pmsr_pkg::CFG_TICKS, 14'(tps));
    @(negedge clk);
  endtask

  initial begin
    min_spd    = pmsr_pkg::MIN_SPEED_RST;
    full_dty   = pmsr_pkg::FULL_DUTY_RST;
    step_ticks = pmsr_pkg::TICKS_RST;
    for (int k = 0; k < pmsr_pkg::MOTOR_COUNT; k++) begin
      spd_now[k]  = '0;
      dir_now[k]  = 1'b1;
      spd_goal[k] = '0;
      dir_goal[k] = 1'b1;
      ramp_ph[k]  = pmsr_pkg::PH_IDLE;
      wait_cnt[k] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    src_idle_pct = 21;
    snk_idle_pct = 57;

    // Directed requests at the reset settings
    queue_req(pmsr_pkg::KIND_TICK, 4'd0, 7'd0, 1'b0);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd0, 7'd127, 1'b1);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd1, 7'd10, 1'b0);
    queue_req(pmsr_pkg::KIND_TICK, 4'd15, 7'd127, 1'b1);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd1, 7'd30, 1'b0);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd0, 7'd60, 1'b0);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd1, 7'd0, 1'b0);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd1, 7'd20, 1'b1);
    queue_req(pmsr_pkg::KIND_TICK, 4'd0, 7'd0, 1'b0);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd2, 7'd50, 1'b1);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd15, 7'd127, 1'b0);
    queue_req(pmsr_pkg::KIND_NONE, 4'd5, 7'd85, 1'b1);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd1, 7'd70, 1'b1);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd0, 7'd0, 1'b0);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd0, 7'd29, 1'b0);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd1, 7'd45, 1'b0);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd1, 7'd29, 1'b1);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd1, 7'd10, 1'b0);
    queue_req(pmsr_pkg::KIND_DIRECT, 4'd0, 7'd100, 1'b1);
    queue_req(pmsr_pkg::KIND_SOFT, 4'd0, 7'd101, 1'b1);
    repeat (4) queue_req(pmsr_pkg::KIND_TICK, 4'd0, 7'd0, 1'b0);
    drain();

    // Extreme settings, sender sparse and receiver busy
    set_regs(1, 16383, 1);
    queue_random(60);
    drain();
    set_regs(99, 1, 2);
    queue_random(40);
    drain();

    // Minimum above a hundred and a zero step length, roles swapped
    src_idle_pct = 57;
    snk_idle_pct = 21;
    set_regs(110, 12000, 0);
    queue_random(30);
    drain();
    set_regs(20, 5000, 1023);
    queue_random(20);
    drain();

    // Receiver stops for a long stretch while requests keep coming
    set_regs($urandom_range(1, 99), $urandom_range(1, 16383), $urandom_range(1, 3));
    queue_random(30);
    holds_asked++;
    queue_random(30);
    drain();

    // No idling; sender pauses midway until all duties are in
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_regs($urandom_range(1, 99), $urandom_range(1, 16383), $urandom_range(1, 3));
    queue_random(35);
    drain();
    queue_random(35);
    drain();

    repeat (200) @(posedge clk);
    if (errors == 0 && duty_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> pwm_motor_soft_start_ramp.f
rtl/pmsr_pkg.sv
rtl/pwm_motor_soft_start_ramp.sv
rtl/pmsr_checker.sv
tb/tb.sv
